### hdl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared widths, constants and stage tag types of the Schlick reflectance core.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Cosine and polynomial terms are Q0.28 held in 29 bits.
  localparam int C_W = 29;
  localparam logic [C_W-1:0] ONE_Q28 = 29'h1000_0000;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [15:0] ONE_Q15 = 16'h8000;

  // Pipelined restoring divider, two lanes in lockstep.
  localparam int DIV_NW = 58;
  localparam int DIV_DW = 30;
  localparam int DIV_QW = 31;
  localparam int DIV_LANES = 2;

  // Pipelined integer square root, one result bit per stage.
  localparam int SQ_W = 58;
  localparam int SQ_STEPS = 29;

  typedef struct packed {
    logic tir;
    logic refr;
    logic sumz;
    logic [C_W-1:0] c;
  } sfr_div_tag_t;

  typedef struct packed {
    logic tir;
    logic refr;
    logic [C_W-1:0] c;
    logic [30:0] r0;
  } sfr_sqrt_tag_t;

endpackage

### hdl/sfr_divide.sv
// ----------------------------------------------------------------------------
// sfr_divide
// Two-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module sfr_divide (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         en,
  input  logic                                         in_valid,
  input  sfr_pkg::sfr_div_tag_t                        in_tag,
  input  logic [sfr_pkg::DIV_LANES-1:0][sfr_pkg::DIV_NW-1:0] in_num,
  input  logic [sfr_pkg::DIV_LANES-1:0][sfr_pkg::DIV_DW-1:0] in_den,
  output logic                                         out_valid,
  output sfr_pkg::sfr_div_tag_t                        out_tag,
  output logic [sfr_pkg::DIV_LANES-1:0][sfr_pkg::DIV_QW-1:0] out_quo
);
  import sfr_pkg::*;

  localparam int SH_W = DIV_DW + DIV_QW;

  logic                                  valid_r [DIV_QW];
  sfr_div_tag_t                          tag_r   [DIV_QW];
  logic [DIV_LANES-1:0][DIV_NW-1:0]      rem_r   [DIV_QW];
  logic [DIV_LANES-1:0][DIV_DW-1:0]      den_r   [DIV_QW];
  logic [DIV_LANES-1:0][DIV_QW-1:0]      quo_r   [DIV_QW];

  genvar s, l;
  for (s = 0; s < DIV_QW; s++) begin : g_stage
    localparam int K = DIV_QW - 1 - s;
    logic                             valid_in;
    sfr_div_tag_t                     tag_in;
    logic [DIV_LANES-1:0][DIV_NW-1:0] rem_in;
    logic [DIV_LANES-1:0][DIV_NW-1:0] rem_nxt;
    logic [DIV_LANES-1:0][DIV_DW-1:0] den_in;
    logic [DIV_LANES-1:0][DIV_QW-1:0] quo_in;
    logic [DIV_LANES-1:0][DIV_QW-1:0] quo_nxt;

    if (s == 0) begin : g_first
      assign valid_in = in_valid;
      assign tag_in   = in_tag;
      assign rem_in   = in_num;
      assign den_in   = in_den;
      assign quo_in   = '0;
    end else begin : g_next
      assign valid_in = valid_r[s-1];
      assign tag_in   = tag_r[s-1];
      assign rem_in   = rem_r[s-1];
      assign den_in   = den_r[s-1];
      assign quo_in   = quo_r[s-1];
    end

    for (l = 0; l < DIV_LANES; l++) begin : g_lane
      logic [SH_W-1:0] sh;
      logic [SH_W-1:0] remx;
      always_comb begin
        sh   = {{DIV_QW{1'b0}}, den_in[l]} << K;
        remx = {{(SH_W-DIV_NW){1'b0}}, rem_in[l]};
        rem_nxt[l] = rem_in[l];
        quo_nxt[l] = quo_in[l];
        if (remx >= sh) begin
          rem_nxt[l]    = rem_in[l] - sh[DIV_NW-1:0];
          quo_nxt[l][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[s] <= tag_in;
        rem_r[s] <= rem_nxt;
        den_r[s] <= den_in;
        quo_r[s] <= quo_nxt;
      end
    end
  end

  assign out_valid = valid_r[DIV_QW-1];
  assign out_tag   = tag_r[DIV_QW-1];
  assign out_quo   = quo_r[DIV_QW-1];

endmodule

### hdl/sfr_sqrt.sv
// ----------------------------------------------------------------------------
// sfr_sqrt
// Digit-by-digit integer square root, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module sfr_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  sfr_pkg::sfr_sqrt_tag_t     in_tag,
  input  logic [sfr_pkg::SQ_W-1:0]   in_value,
  output logic                       out_valid,
  output sfr_pkg::sfr_sqrt_tag_t     out_tag,
  output logic [sfr_pkg::C_W-1:0]    out_root
);
  import sfr_pkg::*;

  logic            valid_r [SQ_STEPS];
  sfr_sqrt_tag_t   tag_r   [SQ_STEPS];
  logic [SQ_W-1:0] val_r   [SQ_STEPS];
  logic [SQ_W-1:0] root_r  [SQ_STEPS];

  genvar s;
  for (s = 0; s < SQ_STEPS; s++) begin : g_stage
    localparam int B = 2 * (SQ_STEPS - 1 - s);
    logic            valid_in;
    sfr_sqrt_tag_t   tag_in;
    logic [SQ_W-1:0] val_in;
    logic [SQ_W-1:0] root_in;
    logic [SQ_W-1:0] val_nxt;
    logic [SQ_W-1:0] root_nxt;
    logic [SQ_W-1:0] trial;

    if (s == 0) begin : g_first
      assign valid_in = in_valid;
      assign tag_in   = in_tag;
      assign val_in   = in_value;
      assign root_in  = '0;
    end else begin : g_next
      assign valid_in = valid_r[s-1];
      assign tag_in   = tag_r[s-1];
      assign val_in   = val_r[s-1];
      assign root_in  = root_r[s-1];
    end

    always_comb begin
      trial = root_in + (SQ_W'(1) << B);
      if (val_in >= trial) begin
        val_nxt  = val_in - trial;
        root_nxt = (root_in >> 1) + (SQ_W'(1) << B);
      end else begin
        val_nxt  = val_in;
        root_nxt = root_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[s]  <= tag_in;
        val_r[s]  <= val_nxt;
        root_r[s] <= root_nxt;
      end
    end
  end

  assign out_valid = valid_r[SQ_STEPS-1];
  assign out_tag   = tag_r[SQ_STEPS-1];
  assign out_root  = root_r[SQ_STEPS-1][C_W-1:0];

endmodule

### hdl/sfr_shade.sv
// ----------------------------------------------------------------------------
// sfr_shade
// Fifth power of one minus cosine, Schlick blend, rounding and output register.
// ----------------------------------------------------------------------------
module sfr_shade (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  sfr_pkg::sfr_sqrt_tag_t   in_tag,
  input  logic [sfr_pkg::C_W-1:0]  in_root,
  output logic                     out_valid,
  output logic [15:0]              out_reflectance,
  output logic                     out_total_internal
);
  import sfr_pkg::*;

  localparam int PW = 4;

  // Stage 0: final cosine and x = 1 - cosine.
  logic           v0_r;
  logic           tir0_r;
  logic [C_W-1:0] x0_r;
  logic [30:0]    r00_r;
  logic [C_W-1:0] c_sel;
  logic [C_W-1:0] root_sat;

  always_comb begin
    root_sat = (in_root > ONE_Q28) ? ONE_Q28 : in_root;
    c_sel    = in_tag.refr ? root_sat : in_tag.c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tir0_r <= in_tag.tir;
      x0_r   <= ONE_Q28 - c_sel;
      r00_r  <= in_tag.r0;
    end
  end

  // Four multiply stages build x^5, each product truncated back to Q0.28.
  logic           pv_r   [PW];
  logic           ptir_r [PW];
  logic [C_W-1:0] px_r   [PW];
  logic [C_W-1:0] pp_r   [PW];
  logic [30:0]    pr0_r  [PW];

  genvar s;
  for (s = 0; s < PW; s++) begin : g_pow
    logic           v_in;
    logic           tir_in;
    logic [C_W-1:0] x_in;
    logic [C_W-1:0] p_in;
    logic [30:0]    r0_in;
    logic [2*C_W-1:0] prod;

    if (s == 0) begin : g_first
      assign v_in   = v0_r;
      assign tir_in = tir0_r;
      assign x_in   = x0_r;
      assign p_in   = x0_r;
      assign r0_in  = r00_r;
    end else begin : g_next
      assign v_in   = pv_r[s-1];
      assign tir_in = ptir_r[s-1];
      assign x_in   = px_r[s-1];
      assign p_in   = pp_r[s-1];
      assign r0_in  = pr0_r[s-1];
    end

    assign prod = (2*C_W)'(p_in) * (2*C_W)'(x_in);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pv_r[s] <= 1'b0;
      end else if (en) begin
        pv_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ptir_r[s] <= tir_in;
        px_r[s]   <= x_in;
        pp_r[s]   <= prod[2*C_W-2:C_W-1];
        pr0_r[s]  <= r0_in;
      end
    end
  end

  // Blend stage: (1 - r0) * x^5 in Q0.30.
  logic        vb_r;
  logic        tirb_r;
  logic [30:0] r0b_r;
  logic [30:0] tb_r;
  logic [59:0] blend;

  assign blend = 60'(ONE_Q30 - pr0_r[PW-1]) * 60'(pp_r[PW-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= pv_r[PW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tirb_r <= ptir_r[PW-1];
      r0b_r  <= pr0_r[PW-1];
      tb_r   <= blend[58:28];
    end
  end

  // Output register: round half up to Q1.15 and saturate.
  logic        out_valid_r;
  logic [15:0] refl_r;
  logic        tir_r;
  logic [31:0] rsum;
  logic [16:0] rq;
  logic [15:0] refl_nxt;

  always_comb begin
    rsum = {1'b0, r0b_r} + {1'b0, tb_r} + 32'h0000_4000;
    rq   = rsum[31:15];
    if (tirb_r || (rq > {1'b0, ONE_Q15})) begin
      refl_nxt = ONE_Q15;
    end else begin
      refl_nxt = rq[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      refl_r <= refl_nxt;
      tir_r  <= tirb_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_reflectance    = refl_r;
  assign out_total_internal = tir_r;

endmodule

### hdl/schlick_fresnel_reflectance_core.sv
// ----------------------------------------------------------------------------
// schlick_fresnel_reflectance_core
// Schlick Fresnel reflectance with refraction and total internal reflection.
// ----------------------------------------------------------------------------
// The core takes one beat per clock unless a result is stalled at the output;
// five front stages form the cosine and the squared terms,
// a two-lane divider spends one stage per quotient bit (31 stages) on sin2t
// and r0, one stage forms the root operand, the square root spends one stage
// per root bit (29 stages), and seven stages raise 1 - cosine to the fifth
// power, blend and round. The whole pipeline holds while a finished result
// is stalled at the output, so in_stall follows out_stall in that case only.
module schlick_fresnel_reflectance_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_eye_x,
  input  logic signed [15:0] in_eye_y,
  input  logic signed [15:0] in_eye_z,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic [13:0]        in_index_from,
  input  logic [13:0]        in_index_to,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_reflectance,
  output logic               out_total_internal
);
  import sfr_pkg::*;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [4:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  // Stage 1: component products.
  logic signed [31:0] px_r, py_r, pz_r;
  logic [13:0]        n1_r, n2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= 32'(in_eye_x) * 32'(in_normal_x);
      py_r <= 32'(in_eye_y) * 32'(in_normal_y);
      pz_r <= 32'(in_eye_z) * 32'(in_normal_z);
      n1_r <= in_index_from;
      n2_r <= in_index_to;
    end
  end

  // Stage 2: clamped cosine, index squares, difference and sum.
  logic signed [33:0] dot;
  logic [C_W-1:0]     c_nxt;
  logic [C_W-1:0]     c2_r;
  logic [27:0]        n1sq2_r, n2sq2_r;
  logic [13:0]        diff2_r;
  logic [14:0]        sum2_r;
  logic               refr2_r, n2z2_r;

  always_comb begin
    dot = 34'(px_r) + 34'(py_r) + 34'(pz_r);
    if (dot[33]) begin
      c_nxt = '0;
    end else if (dot > 34'sd268435456) begin
      c_nxt = ONE_Q28;
    end else begin
      c_nxt = dot[C_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r    <= c_nxt;
      n1sq2_r <= 28'(n1_r) * 28'(n1_r);
      n2sq2_r <= 28'(n2_r) * 28'(n2_r);
      diff2_r <= (n1_r > n2_r) ? (n1_r - n2_r) : (n2_r - n1_r);
      sum2_r  <= {1'b0, n1_r} + {1'b0, n2_r};
      refr2_r <= n1_r > n2_r;
      n2z2_r  <= n2_r == 14'd0;
    end
  end

  // Stage 3: cosine squared and the squares that feed r0.
  logic [C_W-1:0] c3_r;
  logic [56:0]    csq3_r;
  logic [27:0]    n1sq3_r, n2sq3_r, dsq3_r;
  logic [29:0]    ssq3_r;
  logic           refr3_r, n2z3_r, sumz3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c3_r    <= c2_r;
      csq3_r  <= 57'(c2_r) * 57'(c2_r);
      n1sq3_r <= n1sq2_r;
      n2sq3_r <= n2sq2_r;
      dsq3_r  <= 28'(diff2_r) * 28'(diff2_r);
      ssq3_r  <= 30'(sum2_r) * 30'(sum2_r);
      refr3_r <= refr2_r;
      n2z3_r  <= n2z2_r;
      sumz3_r <= sum2_r == 15'd0;
    end
  end

  // Stage 4: one minus cosine squared, truncated to Q0.28.
  localparam logic [56:0] ONE_Q56 = 57'd1 << 56;
  logic [56:0]    omc2_full;
  logic [C_W-1:0] c4_r, omc4_r;
  logic [27:0]    n1sq4_r, n2sq4_r, dsq4_r;
  logic [29:0]    ssq4_r;
  logic           refr4_r, n2z4_r, sumz4_r;

  assign omc2_full = ONE_Q56 - csq3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c4_r    <= c3_r;
      omc4_r  <= omc2_full[56:28];
      n1sq4_r <= n1sq3_r;
      n2sq4_r <= n2sq3_r;
      dsq4_r  <= dsq3_r;
      ssq4_r  <= ssq3_r;
      refr4_r <= refr3_r;
      n2z4_r  <= n2z3_r;
      sumz4_r <= sumz3_r;
    end
  end

  // Stage 5: sin2t numerator.
  logic [C_W-1:0] c5_r;
  logic [56:0]    num5_r;
  logic [27:0]    n2sq5_r, dsq5_r;
  logic [29:0]    ssq5_r;
  logic           refr5_r, n2z5_r, sumz5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c5_r    <= c4_r;
      num5_r  <= 57'(n1sq4_r) * 57'(omc4_r);
      n2sq5_r <= n2sq4_r;
      dsq5_r  <= dsq4_r;
      ssq5_r  <= ssq4_r;
      refr5_r <= refr4_r;
      n2z5_r  <= n2z4_r;
      sumz5_r <= sumz4_r;
    end
  end

  // Total internal reflection is decided exactly, ahead of the divide.
  sfr_div_tag_t                     div_tag_in;
  logic [DIV_LANES-1:0][DIV_NW-1:0] div_num;
  logic [DIV_LANES-1:0][DIV_DW-1:0] div_den;
  logic                             div_valid;
  sfr_div_tag_t                     div_tag;
  logic [DIV_LANES-1:0][DIV_QW-1:0] div_quo;

  always_comb begin
    div_tag_in.tir  = refr5_r && (n2z5_r || (num5_r > {1'b0, n2sq5_r, 28'd0}));
    div_tag_in.refr = refr5_r;
    div_tag_in.sumz = sumz5_r;
    div_tag_in.c    = c5_r;
    div_num[0]      = {1'b0, num5_r};
    div_den[0]      = {2'b00, n2sq5_r};
    div_num[1]      = {dsq5_r, 30'd0};
    div_den[1]      = ssq5_r;
  end

  sfr_divide u_divide (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (vld_r[4]),
    .in_tag   (div_tag_in),
    .in_num   (div_num),
    .in_den   (div_den),
    .out_valid(div_valid),
    .out_tag  (div_tag),
    .out_quo  (div_quo)
  );

  // Root operand (1 - sin2t) in Q0.56, and r0 limited to one.
  logic           sq_vld_r;
  sfr_sqrt_tag_t  sq_tag_r;
  logic [SQ_W-1:0] sq_val_r;
  logic [C_W-1:0] cos_sq;

  assign cos_sq = ONE_Q28 - div_quo[0][C_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else if (en) begin
      sq_vld_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_tag_r.tir  <= div_tag.tir;
      sq_tag_r.refr <= div_tag.refr;
      sq_tag_r.c    <= div_tag.c;
      if (div_tag.sumz) begin
        sq_tag_r.r0 <= '0;
      end else if (div_quo[1] > ONE_Q30) begin
        sq_tag_r.r0 <= ONE_Q30;
      end else begin
        sq_tag_r.r0 <= div_quo[1];
      end
      sq_val_r <= {1'b0, cos_sq, 28'd0};
    end
  end

  logic          rt_valid;
  sfr_sqrt_tag_t rt_tag;
  logic [C_W-1:0] rt_root;

  sfr_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sq_vld_r),
    .in_tag   (sq_tag_r),
    .in_value (sq_val_r),
    .out_valid(rt_valid),
    .out_tag  (rt_tag),
    .out_root (rt_root)
  );

  sfr_shade u_shade (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (en),
    .in_valid          (rt_valid),
    .in_tag            (rt_tag),
    .in_root           (rt_root),
    .out_valid         (out_valid),
    .out_reflectance   (out_reflectance),
    .out_total_internal(out_total_internal)
  );

endmodule

### hdl/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level assertions for the Schlick reflectance core, bound to the top.
// ----------------------------------------------------------------------------
module sfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_reflectance,
  input logic        out_total_internal
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_reflectance)
      && $stable(out_total_internal))
    else $error("result beat changed while stalled");

  // The input only stalls behind a stalled result.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back pressure");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reflectance <= 16'h8000)
    else $error("reflectance above one");

  a_tir_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_total_internal |-> out_reflectance == 16'h8000)
    else $error("total internal reflection without full reflectance");

endmodule

bind schlick_fresnel_reflectance_core sfr_checker u_sfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_reflectance   (out_reflectance),
  .out_total_internal(out_total_internal)
);
